// ===== hw/rtl/asfp_pkg.sv =====
`timescale 1ns / 1ps

package asfp_pkg;

	localparam int FIFO_DEPTH  = 4096;
	localparam int ADDR_W      = $clog2(FIFO_DEPTH);
	localparam int PTR_W       = ADDR_W + 1;
	localparam int SAMPLE_W    = 16;
	localparam int LEVEL_W     = 9;
	localparam int ROOM_W      = 13;

	localparam logic [SAMPLE_W-1:0] SIGN_BIAS = SAMPLE_W'(1) << (SAMPLE_W - 1);
	localparam logic [PTR_W-1:0]    DEPTH_PTR = PTR_W'(FIFO_DEPTH);

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] duty_level;
		logic               level_valid;
		logic               dropped;
		logic               underflow;
		logic [ROOM_W-1:0]  free_room;
	} out_beat_t;

	typedef struct packed {
		logic                wr_en;
		logic [ADDR_W-1:0]   wr_addr;
		logic [SAMPLE_W-1:0] wr_data;
		logic                rd_en;
		logic [ADDR_W-1:0]   rd_addr;
	} ram_req_t;

	typedef struct packed {
		logic              use_mem;
		logic              level_valid;
		logic              dropped;
		logic              underflow;
		logic [ROOM_W-1:0] free_room;
	} meta_t;

endpackage

// ===== hw/rtl/asfp_ram.sv =====
`timescale 1ns / 1ps

module asfp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/asfp_ctrl.sv =====
`timescale 1ns / 1ps

module asfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  asfp_pkg::in_beat_t beat,
	output asfp_pkg::ram_req_t ram_req,
	output asfp_pkg::meta_t    meta
);

	logic [asfp_pkg::PTR_W-1:0] wptr_q, rptr_q, wptr_nx, rptr_nx;
	logic [asfp_pkg::PTR_W-1:0] held, held_nx;
	logic                       full, empty, do_push, do_pop;

	always_comb begin
		held    = wptr_q - rptr_q;
		full    = (held == asfp_pkg::DEPTH_PTR);
		empty   = (held == '0);
		do_push = accept && (beat.kind == asfp_pkg::KIND_PUSH) && !full;
		do_pop  = accept && (beat.kind == asfp_pkg::KIND_TICK) && !empty;
		wptr_nx = do_push ? wptr_q + 1'b1 : wptr_q;
		rptr_nx = do_pop ? rptr_q + 1'b1 : rptr_q;
		held_nx = wptr_nx - rptr_nx;

		ram_req.wr_en   = do_push;
		ram_req.wr_addr = wptr_q[asfp_pkg::ADDR_W-1:0];
		ram_req.wr_data = beat.sample;
		ram_req.rd_en   = do_pop;
		ram_req.rd_addr = rptr_q[asfp_pkg::ADDR_W-1:0];

		meta.use_mem     = do_pop;
		meta.level_valid = (beat.kind == asfp_pkg::KIND_TICK);
		meta.dropped     = (beat.kind == asfp_pkg::KIND_PUSH) && full;
		meta.underflow   = (beat.kind == asfp_pkg::KIND_TICK) && empty;
		meta.free_room   = asfp_pkg::ROOM_W'(asfp_pkg::DEPTH_PTR - held_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			wptr_q <= wptr_nx;
			rptr_q <= rptr_nx;
		end
	end

endmodule

// ===== hw/rtl/audio_sample_fifo_to_pwm_level.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// src      in   src_valid/src_stall  asfp_pkg::in_beat_t  (push or tick)
// dst      out  dst_valid/dst_stall  asfp_pkg::out_beat_t (one per src beat)
//
// One beat per cycle sustained while dst_stall does not hold the output; the
// result is registered in the RAM read stage, then in the output register.
// Pointers and the sample RAM (4096 x 16, one write and one read port) set the
// rate: a push writes and a tick reads in the cycle of acceptance.
// Reset clears pointers and valids only; RAM contents are not cleared.
// dst_stall holds the output register and, if the read stage is full, stalls src.

module audio_sample_fifo_to_pwm_level (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  asfp_pkg::in_beat_t  src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output asfp_pkg::out_beat_t dst_data
);

	logic                          accept, adv;
	asfp_pkg::ram_req_t            ram_req;
	asfp_pkg::meta_t               meta, meta_s1;
	logic                          valid_s1, out_valid_q;
	logic [asfp_pkg::SAMPLE_W-1:0] rd_data, smp, biased;
	asfp_pkg::out_beat_t           res, out_q;

	assign adv       = !out_valid_q || !dst_stall;
	assign src_stall = valid_s1 && !adv;
	assign accept    = src_valid && !src_stall;

	asfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.beat    (src_data),
		.ram_req (ram_req),
		.meta    (meta)
	);

	asfp_ram #(
		.WIDTH (asfp_pkg::SAMPLE_W),
		.DEPTH (asfp_pkg::FIFO_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// silence is zero, biasing gives mid level
	always_comb begin
		smp    = meta_s1.use_mem ? rd_data : '0;
		biased = smp ^ asfp_pkg::SIGN_BIAS;
		res.duty_level  = meta_s1.level_valid ?
			biased[asfp_pkg::SAMPLE_W-1 -: asfp_pkg::LEVEL_W] : '0;
		res.level_valid = meta_s1.level_valid;
		res.dropped     = meta_s1.dropped;
		res.underflow   = meta_s1.underflow;
		res.free_room   = meta_s1.free_room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q <= res;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && out_valid_q && dst_stall))
		else $error("src stalled with read stage free");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> !(dst_data.dropped && dst_data.underflow))
		else $error("drop and underflow on one beat");

	a_room_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (dst_data.free_room <= asfp_pkg::ROOM_W'(asfp_pkg::FIFO_DEPTH)))
		else $error("free room beyond depth");

	a_underflow_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.underflow) |->
		(dst_data.level_valid &&
		dst_data.duty_level == asfp_pkg::LEVEL_W'(1 << (asfp_pkg::LEVEL_W - 1))))
		else $error("underflow without mid level");

endmodule
